### rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types, constants and the sequencer microcode for the RC4 unit.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W       = 8;
    localparam int SBOX_DEPTH   = 256;
    localparam int KEY_MAX_DEF  = 256;
    localparam int KEY_LEN_W    = 9;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 9'd250;

    // request opcodes
    localparam logic [1:0] OP_LOAD_KEY = 2'd0;
    localparam logic [1:0] OP_SCHEDULE = 2'd1;
    localparam logic [1:0] OP_DATA     = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] cipher_byte;
        logic [BYTE_W-1:0] keystream_byte;
        logic              schedule_done;
    } res_t;

    // sequencer steps (microcode addresses)
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_INIT,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_FIN
    } step_t;

    // state box read address select
    typedef enum logic [2:0] {
        SA_I1,      // i + 1
        SA_J,       // updated j
        SA_T,       // S[i] + S[j]
        SA_N,       // schedule counter
        SA_N1       // schedule counter + 1
    } sa_sel_t;

    // state box write select
    typedef enum logic [2:0] {
        SW_NONE,
        SW_N_IDX,   // S[n] = n
        SW_J_SI,    // S[j] = saved S[i]
        SW_I_SJ,    // S[i] = saved S[j]
        SW_N_SJ     // S[n] = saved S[j]
    } sw_sel_t;

    typedef enum logic [1:0] {
        J_HOLD,
        J_ADD,      // j + S[x]
        J_KEY,      // j + S[x] + K[x]
        J_CLR
    } j_sel_t;

    typedef enum logic [1:0] {
        K_HOLD,
        K_CLR,
        K_ADV
    } k_op_t;

    typedef enum logic [1:0] {
        C_NEXT,
        C_DISPATCH,
        C_N_LAST
    } cond_t;

    typedef struct packed {
        logic    accept;
        sa_sel_t sa_sel;
        sw_sel_t sw_sel;
        j_sel_t  j_sel;
        k_op_t   k_op;
        logic    si_ld;
        logic    sj_ld;
        logic    n_inc;
        logic    fin_clr;
        logic    emit_data;
        logic    emit_sched;
        cond_t   cond;
        step_t   next_step;
        step_t   jump_step;
    } ctl_t;

    // Microcode ROM: one control word per step.
    function automatic ctl_t ucode(input step_t s);
        ctl_t c;
        c.accept     = 1'b0;
        c.sa_sel     = SA_I1;
        c.sw_sel     = SW_NONE;
        c.j_sel      = J_HOLD;
        c.k_op       = K_HOLD;
        c.si_ld      = 1'b0;
        c.sj_ld      = 1'b0;
        c.n_inc      = 1'b0;
        c.fin_clr    = 1'b0;
        c.emit_data  = 1'b0;
        c.emit_sched = 1'b0;
        c.cond       = C_NEXT;
        c.next_step  = ST_IDLE;
        c.jump_step  = ST_IDLE;
        case (s)
            ST_IDLE:
            begin
                c.accept = 1'b1;
                c.sa_sel = SA_I1;
                c.cond   = C_DISPATCH;
            end
            ST_D1:
            begin
                c.sa_sel    = SA_J;
                c.j_sel     = J_ADD;
                c.si_ld     = 1'b1;
                c.next_step = ST_D2;
            end
            ST_D2:
            begin
                c.sa_sel    = SA_T;
                c.sw_sel    = SW_J_SI;
                c.sj_ld     = 1'b1;
                c.next_step = ST_D3;
            end
            ST_D3:
            begin
                c.accept    = 1'b1;
                c.sa_sel    = SA_I1;
                c.sw_sel    = SW_I_SJ;
                c.emit_data = 1'b1;
                c.cond      = C_DISPATCH;
            end
            ST_INIT:
            begin
                c.sw_sel    = SW_N_IDX;
                c.j_sel     = J_CLR;
                c.k_op      = K_CLR;
                c.n_inc     = 1'b1;
                c.cond      = C_N_LAST;
                c.next_step = ST_INIT;
                c.jump_step = ST_M0;
            end
            ST_M0:
            begin
                c.sa_sel    = SA_N;
                c.next_step = ST_M1;
            end
            ST_M1:
            begin
                c.sa_sel    = SA_J;
                c.j_sel     = J_KEY;
                c.si_ld     = 1'b1;
                c.next_step = ST_M2;
            end
            ST_M2:
            begin
                c.sw_sel    = SW_J_SI;
                c.sj_ld     = 1'b1;
                c.next_step = ST_M3;
            end
            ST_M3:
            begin
                c.sa_sel    = SA_N1;
                c.sw_sel    = SW_N_SJ;
                c.k_op      = K_ADV;
                c.n_inc     = 1'b1;
                c.cond      = C_N_LAST;
                c.next_step = ST_M1;
                c.jump_step = ST_FIN;
            end
            ST_FIN:
            begin
                c.fin_clr    = 1'b1;
                c.emit_sched = 1'b1;
            end
            default:
            begin
                c.next_step = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

### rtl/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read at the written address returns the old entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rc4_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit: RC4 engine run by a microcoded sequencer.
// Key load: accepted with no result. Data byte: steps D1, D2 and D3; D3 posts
// the result and takes the next request (set by the single state-box RAM port pair).
// Key schedule: INIT over every entry, then M0, then M1-M3 for each entry, then FIN,
// which posts the result. Reset clears control and sets the key length to 250; state
// box and key store hold no value until loaded and scheduled.
module rc4_stream_cipher_unit #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  rc4_pkg::cmd_t                  cmd,
    // result channel
    output logic                           res_valid,
    input  logic                           res_stall,
    output rc4_pkg::res_t                  res,
    // key length register write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rc4_pkg::KEY_LEN_W-1:0]  cfg_data
);

    localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int BW     = rc4_pkg::BYTE_W;
    localparam int LW     = rc4_pkg::KEY_LEN_W;

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    rc4_pkg::step_t    step_reg, step_next;
    rc4_pkg::ctl_t     cw;

    logic [BW-1:0]     i_reg, i_next;         // PRGA index i
    logic [BW-1:0]     j_reg, j_next;         // PRGA / schedule index j
    logic [BW-1:0]     n_reg, n_next;         // schedule step counter
    logic [BW-1:0]     si_reg, si_next;       // saved S[i] (or S[n])
    logic [BW-1:0]     sj_reg, sj_next;       // saved S[j]
    logic [BW-1:0]     t_reg, t_next;         // keystream index
    logic [BW-1:0]     data_reg, data_next;   // data byte of the request in flight
    logic [KEY_AW-1:0] kidx_reg, kidx_next;   // key position in schedule
    logic [KEY_AW-1:0] kwi_reg, kwi_next;     // key write pointer
    logic [LW-1:0]     key_length_reg, key_length_next;
    logic              res_valid_reg, res_valid_next;
    rc4_pkg::res_t     res_reg, res_next;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic              s_we, s_re;
    logic [BW-1:0]     s_waddr, s_wdata, s_raddr, s_rdata;
    logic              k_we;
    logic [KEY_AW-1:0] k_raddr;
    logic [BW-1:0]     k_rdata;

    // combinational helpers
    logic              emit;
    logic              advance;
    logic              accept_fire;
    logic [BW-1:0]     j_new;
    logic [BW-1:0]     t_sum;
    logic [LW-1:0]     len_m1;
    logic [KEY_AW-1:0] kidx_inc;
    logic [BW-1:0]     ks;

    // The control word is a pure function of the step counter.
    assign cw = rc4_pkg::ucode(step_reg);

    // A step that posts a result waits while the output register is still
    // full and stalled; nothing in the datapath moves during the wait.
    assign emit        = cw.emit_data | cw.emit_sched;
    assign advance     = !(emit && res_valid_reg && res_stall);
    assign accept_fire = cw.accept && advance && cmd_valid;

    assign cmd_stall = !(cw.accept && advance);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Effective key length minus one: zero counts as one, clamp at KEY_MAX.
    always_comb
    begin
        if (key_length_reg == '0)
        begin
            len_m1 = '0;
        end
        else if (key_length_reg > LW'(KEY_MAX))
        begin
            len_m1 = LW'(KEY_MAX - 1);
        end
        else
        begin
            len_m1 = key_length_reg - 1'b1;
        end
    end

    // key index wraps at the effective length (n mod len)
    assign kidx_inc = (LW'(kidx_reg) == len_m1) ? '0 : kidx_reg + 1'b1;

    // j update: PRGA adds S[i]; schedule adds S[n] and the key byte
    always_comb
    begin
        case (cw.j_sel)
            rc4_pkg::J_ADD: j_new = j_reg + s_rdata;
            rc4_pkg::J_KEY: j_new = j_reg + s_rdata + k_rdata;
            rc4_pkg::J_CLR: j_new = '0;
            default:        j_new = j_reg;
        endcase
    end

    assign t_sum = si_reg + s_rdata;

    // Keystream read was issued while S[j] = S[i] was being written, and
    // S[i] = S[j] lands in the same cycle as the result, so the RAM returns
    // the pre-swap entry. Forward the swapped values when t hits i or j.
    always_comb
    begin
        if (t_reg == i_reg)
        begin
            ks = sj_reg;
        end
        else if (t_reg == j_reg)
        begin
            ks = si_reg;
        end
        else
        begin
            ks = s_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Next step (microcode sequencing with conditional jumps)
    // ------------------------------------------------------------------
    always_comb
    begin
        step_next = step_reg;
        if (advance)
        begin
            case (cw.cond)
                rc4_pkg::C_N_LAST:
                begin
                    step_next = (n_reg == '1) ? cw.jump_step : cw.next_step;
                end
                rc4_pkg::C_DISPATCH:
                begin
                    step_next = cw.next_step;
                    if (accept_fire)
                    begin
                        case (cmd.opcode)
                            rc4_pkg::OP_DATA:     step_next = rc4_pkg::ST_D1;
                            rc4_pkg::OP_SCHEDULE: step_next = rc4_pkg::ST_INIT;
                            default:              step_next = cw.next_step;
                        endcase
                    end
                end
                default:
                begin
                    step_next = cw.next_step;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath controls
    // ------------------------------------------------------------------
    always_comb
    begin
        // state box read address
        case (cw.sa_sel)
            rc4_pkg::SA_I1: s_raddr = i_reg + 1'b1;
            rc4_pkg::SA_J:  s_raddr = j_new;
            rc4_pkg::SA_T:  s_raddr = t_sum;
            rc4_pkg::SA_N:  s_raddr = n_reg;
            rc4_pkg::SA_N1: s_raddr = n_reg + 1'b1;
            default:        s_raddr = i_reg + 1'b1;
        endcase
        s_re = advance;

        // state box write
        s_we    = advance;
        s_waddr = n_reg;
        s_wdata = n_reg;
        case (cw.sw_sel)
            rc4_pkg::SW_N_IDX:
            begin
                s_waddr = n_reg;
                s_wdata = n_reg;
            end
            rc4_pkg::SW_J_SI:
            begin
                s_waddr = j_reg;
                s_wdata = si_reg;
            end
            rc4_pkg::SW_I_SJ:
            begin
                s_waddr = i_reg;
                s_wdata = sj_reg;
            end
            rc4_pkg::SW_N_SJ:
            begin
                s_waddr = n_reg;
                s_wdata = sj_reg;
            end
            default:
            begin
                s_we = 1'b0;
            end
        endcase

        // key store: write on load requests, read ahead of the mixing step
        k_we    = accept_fire && (cmd.opcode == rc4_pkg::OP_LOAD_KEY);
        k_raddr = (cw.k_op == rc4_pkg::K_ADV) ? kidx_inc : kidx_reg;
    end

    // ------------------------------------------------------------------
    // Register next values
    // ------------------------------------------------------------------
    always_comb
    begin
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        si_next         = si_reg;
        sj_next         = sj_reg;
        t_next          = t_reg;
        data_next       = data_reg;
        kidx_next       = kidx_reg;
        kwi_next        = kwi_reg;
        key_length_next = key_length_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;

        if (cfg_valid)
        begin
            key_length_next = cfg_data;
        end

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        if (advance)
        begin
            j_next = j_new;
            if (cw.si_ld)
            begin
                si_next = s_rdata;
            end
            if (cw.sj_ld)
            begin
                sj_next = s_rdata;
                t_next  = t_sum;
            end
            if (cw.n_inc)
            begin
                n_next = n_reg + 1'b1;
            end
            case (cw.k_op)
                rc4_pkg::K_CLR: kidx_next = '0;
                rc4_pkg::K_ADV: kidx_next = kidx_inc;
                default:        kidx_next = kidx_reg;
            endcase
            if (cw.fin_clr)
            begin
                i_next   = '0;
                j_next   = '0;
                kwi_next = '0;
            end
            if (cw.emit_data)
            begin
                res_valid_next          = 1'b1;
                res_next.cipher_byte    = data_reg ^ ks;
                res_next.keystream_byte = ks;
                res_next.schedule_done  = 1'b0;
            end
            if (cw.emit_sched)
            begin
                res_valid_next          = 1'b1;
                res_next.cipher_byte    = '0;
                res_next.keystream_byte = '0;
                res_next.schedule_done  = 1'b1;
            end
        end

        if (accept_fire)
        begin
            data_next = cmd.data_byte;
            case (cmd.opcode)
                rc4_pkg::OP_LOAD_KEY:
                begin
                    kwi_next = (kwi_reg == KEY_AW'(KEY_MAX - 1)) ? '0 : kwi_reg + 1'b1;
                end
                rc4_pkg::OP_DATA:
                begin
                    i_next = i_reg + 1'b1;
                end
                default:
                begin
                    i_next = i_next;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= rc4_pkg::ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            n_reg          <= '0;
            kidx_reg       <= '0;
            kwi_reg        <= '0;
            key_length_reg <= rc4_pkg::KEY_LEN_RST;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            n_reg          <= n_next;
            kidx_reg       <= kidx_next;
            kwi_reg        <= kwi_next;
            key_length_reg <= key_length_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        t_reg    <= t_next;
        data_reg <= data_next;
        res_reg  <= res_next;
    end

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    rc4_ram #(
        .WIDTH (BW),
        .DEPTH (rc4_pkg::SBOX_DEPTH)
    ) u_sbox (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    rc4_ram #(
        .WIDTH (BW),
        .DEPTH (KEY_MAX)
    ) u_key (
        .clk   (clk),
        .we    (k_we),
        .waddr (kwi_reg),
        .wdata (cmd.data_byte),
        .re    (1'b1),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

endmodule
